// ===== design/tsc_pkg.sv =====
// Package for the twilight shade classifier: grid size, fixed-point constants,
// sine approximation coefficients and zone codes. No dependencies.
package tsc_pkg;

  // Grid size in cells; both are powers of two so the angle scaling is a shift.
  localparam int GridWidth  = 256;
  localparam int GridHeight = 128;

  localparam logic [15:0] SinA = 16'd51472;
  localparam logic [14:0] SinB = 15'd21024;
  localparam logic [11:0] SinC = 12'd2320;

  localparam logic signed [47:0] Hav90  = 48'sd536870912 <<< 16;
  localparam logic signed [47:0] Hav96  = 48'sd592989203 <<< 16;
  localparam logic signed [47:0] Hav102 = 48'sd648492651 <<< 16;
  localparam logic signed [47:0] Hav108 = 48'sd702773148 <<< 16;

  localparam logic [2:0] ZoneDay    = 3'd0;
  localparam logic [2:0] ZoneCivil  = 3'd1;
  localparam logic [2:0] ZoneNaut   = 3'd2;
  localparam logic [2:0] ZoneAstro  = 3'd3;
  localparam logic [2:0] ZoneNight  = 3'd4;

  localparam logic [1:0] RegSunLon = 2'd0;
  localparam logic [1:0] RegSunLat = 2'd1;

endpackage

// ===== design/twilight_shade_classifier.sv =====
// Twilight shade classifier top level: a pipelined haversine distance test
// against the configured subsolar point. Depends on tsc_pkg.
//
// Usage: one grid cell (column, row) enters on the s_axis channel per
// transfer; one result (alpha, zone) leaves on m_axis per cell, in order.
// tdata in: [7:0] pixel_column, [14:8] pixel_row.
// tdata out: [7:0] shade_alpha, [10:8] twilight_zone.
// The subsolar longitude (index 0) and latitude (index 1) are to be written over
// the cfg channel while the block is idle, which the block does not enforce; both reset to zero.
// The pipeline has nine register stages of sine polynomial, product, sum and
// compare logic, none deeper than one multiply; throughput is one cell per
// cycle while the receiver does not stall.
// When the receiver stalls the whole pipeline holds; s_axis_tready follows
// m_axis_tready or a free output slot, so nothing is lost or repeated.
// Reset clears all valid bits and the registers; payload is unreset.
module twilight_shade_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] pixel_column, [14:8] pixel_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] shade_alpha, [10:8] twilight_zone
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int NStg = 9;
  localparam int WShift = $clog2(tsc_pkg::GridWidth);
  localparam int HShift = $clog2(tsc_pkg::GridHeight);

  logic [15:0]        sun_lon_q;
  logic signed [15:0] sun_lat_q;
  logic [NStg-1:0]    vld_q;
  logic               adv;

  assign cfg_ready_o = 1'b1;
  assign adv = m_axis_tready | ~vld_q[NStg-1];
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sun_lon_q <= '0;
      sun_lat_q <= '0;
      vld_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tsc_pkg::RegSunLon: sun_lon_q <= cfg_data_i;
          tsc_pkg::RegSunLat: sun_lat_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (adv) vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: angles. Column and row scaling are exact divisions by powers of two.
  logic [7:0]  col;
  logic [6:0]  row;
  logic [15:0] lon_d, lat_d;
  logic [31:0] colx, rowx;
  assign col = s_axis_tdata[7:0];
  assign row = s_axis_tdata[14:8];
  assign colx = {24'd0, col} << 16;
  assign rowx = {25'd0, row} << 15;
  assign lon_d = 16'(colx >> WShift) + 16'h8000;
  assign lat_d = 16'h4000 - 16'(rowx >> HShift);

  // Three cosines run in lanes: cos(dlat), cos(cell_lat), cos(dlon);
  // cos(sun_lat) likewise in lane 3.
  logic [15:0] ang_d [4];
  assign ang_d[0] = (lat_d - sun_lat_q) + 16'h4000;
  assign ang_d[1] = lat_d + 16'h4000;
  assign ang_d[2] = (lon_d - sun_lon_q) + 16'h4000;
  assign ang_d[3] = sun_lat_q + 16'h4000;

  // Stage 1: quadrant fold.
  logic [14:0] t1_q [4];
  logic        n1_q [4];
  // Stage 2: t2. Stage 3: inner. Stage 4: t2*inner. Stage 5: poly*t -> sine.
  logic [14:0] t2s_q [4], t3_q [4], t4_q [4];
  logic [15:0] sq2_q [4], sq3_q [4];
  logic        n2_q [4], n3_q [4], n4_q [4], n5_q [4];
  logic [14:0] in3_q [4];
  logic [16:0] poly4_q [4];
  logic [15:0] s5_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        logic [13:0] r;
        logic [31:0] pa, pb, pc;
        logic [33:0] pd;
        r = ang_d[k][13:0];
        t1_q[k] <= ang_d[k][14] ? 15'(15'd16384 - {1'b0, r}) : {1'b0, r};
        n1_q[k] <= ang_d[k][15];
        pa = t1_q[k] * t1_q[k];
        sq2_q[k] <= 16'(pa >> 14);
        t2s_q[k] <= t1_q[k];
        n2_q[k]  <= n1_q[k];
        pb = sq2_q[k] * tsc_pkg::SinC;
        in3_q[k] <= tsc_pkg::SinB - 15'(pb >> 14);
        sq3_q[k] <= sq2_q[k];
        t3_q[k]  <= t2s_q[k];
        n3_q[k]  <= n2_q[k];
        pc = sq3_q[k] * in3_q[k];
        poly4_q[k] <= {1'b0, tsc_pkg::SinA} - 17'(pc >> 14);
        t4_q[k]  <= t3_q[k];
        n4_q[k]  <= n3_q[k];
        pd = t4_q[k] * poly4_q[k];
        s5_q[k]  <= 16'(pd >> 14);
        n5_q[k]  <= n4_q[k];
      end
    end
  end

  // Stage 6: signed cosines, hav terms, cs*cc.
  logic signed [16:0] cs_c, cc_c, cd_c, cl_c;
  assign cd_c = n5_q[0] ? -$signed({1'b0, s5_q[0]}) : $signed({1'b0, s5_q[0]});
  assign cc_c = n5_q[1] ? -$signed({1'b0, s5_q[1]}) : $signed({1'b0, s5_q[1]});
  assign cl_c = n5_q[2] ? -$signed({1'b0, s5_q[2]}) : $signed({1'b0, s5_q[2]});
  assign cs_c = n5_q[3] ? -$signed({1'b0, s5_q[3]}) : $signed({1'b0, s5_q[3]});

  logic signed [17:0] hlat6_q, hlon6_q;
  logic signed [33:0] cp6_q;
  logic signed [47:0] base7_q;
  logic signed [51:0] prod7_lo_q;
  logic signed [47:0] a8_q;
  logic [7:0]  alpha_q;
  logic [2:0]  zone_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hlat6_q <= 18'sd32768 - 18'(cd_c);
      hlon6_q <= 18'sd32768 - 18'(cl_c);
      cp6_q   <= cs_c * cc_c;
      // Stage 7: cs*cc*hav(dlon), one 34x18 product.
      base7_q    <= 48'(hlat6_q) <<< 30;
      prod7_lo_q <= 52'(cp6_q) * 52'(hlon6_q);
      // Stage 8: sum.
      a8_q    <= base7_q + 48'(prod7_lo_q);
      // Stage 9: compare.
      priority if (a8_q > tsc_pkg::Hav108) begin
        alpha_q <= 8'd255; zone_q <= tsc_pkg::ZoneNight;
      end else if (a8_q > tsc_pkg::Hav102) begin
        alpha_q <= 8'd180; zone_q <= tsc_pkg::ZoneAstro;
      end else if (a8_q > tsc_pkg::Hav96) begin
        alpha_q <= 8'd120; zone_q <= tsc_pkg::ZoneNaut;
      end else if (a8_q > tsc_pkg::Hav90) begin
        alpha_q <= 8'd64; zone_q <= tsc_pkg::ZoneCivil;
      end else begin
        alpha_q <= 8'd0; zone_q <= tsc_pkg::ZoneDay;
      end
    end
  end

  logic unused;
  assign unused = s_axis_tdata[15];

  assign m_axis_tdata = {5'd0, zone_q, alpha_q};

endmodule
